// File: src/rmch_pkg.sv
// ----------------------------------------------------------------------------
// rmch_pkg
// Shared types, widths and the multiply-accumulate step table of the
// closest-hit unit.
// ----------------------------------------------------------------------------
package rmch_pkg;

    localparam int unsigned VEC_W     = 63;
    localparam int unsigned CMP_W     = 21;
    localparam int unsigned OPR_W     = 22;
    localparam int unsigned MUL_W     = 24;
    localparam int unsigned LO_W      = 23;
    localparam int unsigned XPR_W     = 46;
    localparam int unsigned DET_W     = 72;
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned Q_W       = 33;
    localparam int unsigned QN_W      = 17;
    localparam int unsigned DIST_W    = 32;
    localparam int unsigned FACE_W    = 16;
    localparam int unsigned NUM_OPS   = 15;
    localparam int unsigned NUM_X     = 9;
    localparam int unsigned NUM_STEPS = 45;
    localparam int unsigned STEP_W    = 6;

    typedef logic [3:0] t_sel;

    localparam t_sel OP_AB = 4'd0;
    localparam t_sel OP_AC = 4'd3;
    localparam t_sel OP_AE = 4'd6;
    localparam t_sel OP_D  = 4'd9;
    localparam t_sel OP_N  = 4'd12;

    localparam t_sel X_1 = 4'd0;
    localparam t_sel X_2 = 4'd3;
    localparam t_sel X_3 = 4'd6;

    localparam t_sel DST_DETA = 4'd9;
    localparam t_sel DST_DETB = 4'd10;
    localparam t_sel DST_DETG = 4'd11;
    localparam t_sel DST_DETT = 4'd12;
    localparam t_sel DST_DN   = 4'd13;
    localparam t_sel DST_NONE = 4'd15;

    typedef enum logic [1:0] {
        BK_OP,
        BK_XLO,
        BK_XHI
    } t_bkind;

    typedef enum logic [1:0] {
        DIV_T,
        DIV_B,
        DIV_G
    } t_divsel;

    typedef struct packed {
        t_sel   a_sel;
        t_bkind b_kind;
        t_sel   b_sel;
        logic   shift;
        logic   sub;
        logic   first;
        logic   last;
        t_sel   dest;
    } t_step;

    typedef struct packed {
        logic              load;
        logic              mac;
        logic [STEP_W-1:0] step;
        logic              norm;
        logic              eval;
        logic              div_start;
        t_divsel           div_sel;
        logic              update;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic hit_cand;
        logic last;
        logic out_full;
    } t_stat;

    function automatic t_step mk(t_sel a, t_bkind k, t_sel b, logic sh, logic sb,
                                 logic f, logic l, t_sel d);
        t_step s;
        s.a_sel  = a;
        s.b_kind = k;
        s.b_sel  = b;
        s.shift  = sh;
        s.sub    = sb;
        s.first  = f;
        s.last   = l;
        s.dest   = d;
        return s;
    endfunction

    // One component of u x v takes two steps.
    function automatic t_step cross_step(t_sel u, t_sel v, t_sel dst, logic [2:0] j);
        t_step s;
        unique case (j)
            3'd0: s = mk(t_sel'(u + 4'd1), BK_OP, t_sel'(v + 4'd2), 1'b0, 1'b0, 1'b1,
                         1'b0, DST_NONE);
            3'd1: s = mk(t_sel'(u + 4'd2), BK_OP, t_sel'(v + 4'd1), 1'b0, 1'b1, 1'b0,
                         1'b1, dst);
            3'd2: s = mk(t_sel'(u + 4'd2), BK_OP, v, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE);
            3'd3: s = mk(u, BK_OP, t_sel'(v + 4'd2), 1'b0, 1'b1, 1'b0, 1'b1,
                         t_sel'(dst + 4'd1));
            3'd4: s = mk(u, BK_OP, t_sel'(v + 4'd1), 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE);
            3'd5: s = mk(t_sel'(u + 4'd1), BK_OP, v, 1'b0, 1'b1, 1'b0, 1'b1,
                         t_sel'(dst + 4'd2));
            default: s = mk(u, BK_OP, v, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
        endcase
        return s;
    endfunction

    // Each wide cross component enters the dot product as a low and a high half.
    function automatic t_step dot_step(t_sel u, t_sel x, t_sel dst, logic [2:0] j);
        t_step s;
        unique case (j)
            3'd0: s = mk(u, BK_XLO, x, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE);
            3'd1: s = mk(u, BK_XHI, x, 1'b1, 1'b0, 1'b0, 1'b0, DST_NONE);
            3'd2: s = mk(t_sel'(u + 4'd1), BK_XLO, t_sel'(x + 4'd1), 1'b0, 1'b0, 1'b0,
                         1'b0, DST_NONE);
            3'd3: s = mk(t_sel'(u + 4'd1), BK_XHI, t_sel'(x + 4'd1), 1'b1, 1'b0, 1'b0,
                         1'b0, DST_NONE);
            3'd4: s = mk(t_sel'(u + 4'd2), BK_XLO, t_sel'(x + 4'd2), 1'b0, 1'b0, 1'b0,
                         1'b0, DST_NONE);
            3'd5: s = mk(t_sel'(u + 4'd2), BK_XHI, t_sel'(x + 4'd2), 1'b1, 1'b0, 1'b0,
                         1'b1, dst);
            default: s = mk(u, BK_OP, x, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
        endcase
        return s;
    endfunction

    function automatic t_step step_rom(logic [STEP_W-1:0] idx);
        t_step s;
        unique case (idx)
            6'd0:  s = mk(OP_D, BK_OP, OP_N, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE);
            6'd1:  s = mk(t_sel'(OP_D + 4'd1), BK_OP, t_sel'(OP_N + 4'd1), 1'b0, 1'b0,
                          1'b0, 1'b0, DST_NONE);
            6'd2:  s = mk(t_sel'(OP_D + 4'd2), BK_OP, t_sel'(OP_N + 4'd2), 1'b0, 1'b0,
                          1'b0, 1'b1, DST_DN);
            6'd3:  s = cross_step(OP_AC, OP_D, X_1, 3'd0);
            6'd4:  s = cross_step(OP_AC, OP_D, X_1, 3'd1);
            6'd5:  s = cross_step(OP_AC, OP_D, X_1, 3'd2);
            6'd6:  s = cross_step(OP_AC, OP_D, X_1, 3'd3);
            6'd7:  s = cross_step(OP_AC, OP_D, X_1, 3'd4);
            6'd8:  s = cross_step(OP_AC, OP_D, X_1, 3'd5);
            6'd9:  s = cross_step(OP_AE, OP_D, X_2, 3'd0);
            6'd10: s = cross_step(OP_AE, OP_D, X_2, 3'd1);
            6'd11: s = cross_step(OP_AE, OP_D, X_2, 3'd2);
            6'd12: s = cross_step(OP_AE, OP_D, X_2, 3'd3);
            6'd13: s = cross_step(OP_AE, OP_D, X_2, 3'd4);
            6'd14: s = cross_step(OP_AE, OP_D, X_2, 3'd5);
            6'd15: s = cross_step(OP_AC, OP_AE, X_3, 3'd0);
            6'd16: s = cross_step(OP_AC, OP_AE, X_3, 3'd1);
            6'd17: s = cross_step(OP_AC, OP_AE, X_3, 3'd2);
            6'd18: s = cross_step(OP_AC, OP_AE, X_3, 3'd3);
            6'd19: s = cross_step(OP_AC, OP_AE, X_3, 3'd4);
            6'd20: s = cross_step(OP_AC, OP_AE, X_3, 3'd5);
            6'd21: s = dot_step(OP_AB, X_1, DST_DETA, 3'd0);
            6'd22: s = dot_step(OP_AB, X_1, DST_DETA, 3'd1);
            6'd23: s = dot_step(OP_AB, X_1, DST_DETA, 3'd2);
            6'd24: s = dot_step(OP_AB, X_1, DST_DETA, 3'd3);
            6'd25: s = dot_step(OP_AB, X_1, DST_DETA, 3'd4);
            6'd26: s = dot_step(OP_AB, X_1, DST_DETA, 3'd5);
            6'd27: s = dot_step(OP_AE, X_1, DST_DETB, 3'd0);
            6'd28: s = dot_step(OP_AE, X_1, DST_DETB, 3'd1);
            6'd29: s = dot_step(OP_AE, X_1, DST_DETB, 3'd2);
            6'd30: s = dot_step(OP_AE, X_1, DST_DETB, 3'd3);
            6'd31: s = dot_step(OP_AE, X_1, DST_DETB, 3'd4);
            6'd32: s = dot_step(OP_AE, X_1, DST_DETB, 3'd5);
            6'd33: s = dot_step(OP_AB, X_2, DST_DETG, 3'd0);
            6'd34: s = dot_step(OP_AB, X_2, DST_DETG, 3'd1);
            6'd35: s = dot_step(OP_AB, X_2, DST_DETG, 3'd2);
            6'd36: s = dot_step(OP_AB, X_2, DST_DETG, 3'd3);
            6'd37: s = dot_step(OP_AB, X_2, DST_DETG, 3'd4);
            6'd38: s = dot_step(OP_AB, X_2, DST_DETG, 3'd5);
            6'd39: s = dot_step(OP_AB, X_3, DST_DETT, 3'd0);
            6'd40: s = dot_step(OP_AB, X_3, DST_DETT, 3'd1);
            6'd41: s = dot_step(OP_AB, X_3, DST_DETT, 3'd2);
            6'd42: s = dot_step(OP_AB, X_3, DST_DETT, 3'd3);
            6'd43: s = dot_step(OP_AB, X_3, DST_DETT, 3'd4);
            6'd44: s = dot_step(OP_AB, X_3, DST_DETT, 3'd5);
            default: s = mk(OP_AB, BK_OP, OP_AB, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
        endcase
        return s;
    endfunction

endpackage

// File: src/rmch_div.sv
// ----------------------------------------------------------------------------
// rmch_div
// Restoring divider giving floor(num * 65536 / den), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rmch_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_wide,
    input  logic [rmch_pkg::DET_W-1:0]  i_num,
    input  logic [rmch_pkg::DET_W-1:0]  i_den,
    output logic                        o_done,
    output logic                        o_sat,
    output logic [rmch_pkg::Q_W-1:0]    o_quot
);

    localparam int unsigned DW = rmch_pkg::DET_W;
    localparam int unsigned QW = rmch_pkg::Q_W;
    localparam int unsigned NW = rmch_pkg::QN_W;
    localparam int unsigned FW = rmch_pkg::FRAC_W;

    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_low;
    logic [QW-1:0] r_quot;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic          r_done;
    logic          r_sat;
    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic [DW-1:0] w_hi_wide;

    assign w_trial   = {r_rem, r_low[QW-1]};
    assign w_diff    = w_trial - {1'b0, i_den};
    assign w_hi_wide = i_num >> (QW - FW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quot <= '0;
                if (i_wide) begin
                    r_sat <= (w_hi_wide >= i_den);
                    r_rem <= (w_hi_wide >= i_den) ? '0 : w_hi_wide;
                    r_low <= {i_num[QW-FW-1:0], {FW{1'b0}}};
                    r_cnt <= 6'(QW);
                end else begin
                    r_sat <= 1'b0;
                    r_rem <= i_num >> (NW - FW);
                    r_low <= {i_num[NW-FW-1:0], {FW{1'b0}}, {(QW-NW){1'b0}}};
                    r_cnt <= 6'(NW);
                end
            end else if (r_busy) begin
                if (!w_diff[DW]) begin
                    r_rem  <= w_diff[DW-1:0];
                    r_quot <= {r_quot[QW-2:0], 1'b1};
                end else begin
                    r_rem  <= w_trial[DW-1:0];
                    r_quot <= {r_quot[QW-2:0], 1'b0};
                end
                r_low <= {r_low[QW-2:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_sat  = r_sat;
    assign o_quot = r_quot;

endmodule

// File: src/rmch_dp.sv
// ----------------------------------------------------------------------------
// rmch_dp
// Datapath: operand registers, shared multiply-accumulate, determinant
// checks, divider, nearest-hit registers and the result register.
// ----------------------------------------------------------------------------
module rmch_dp #(
    parameter int unsigned MAX_FACES = 65536
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rmch_pkg::t_cmd               i_cmd,
    output rmch_pkg::t_stat              o_stat,
    input  logic [rmch_pkg::VEC_W-1:0]   i_ray_origin,
    input  logic [rmch_pkg::VEC_W-1:0]   i_ray_direction,
    input  logic [rmch_pkg::VEC_W-1:0]   i_vertex_a,
    input  logic [rmch_pkg::VEC_W-1:0]   i_vertex_b,
    input  logic [rmch_pkg::VEC_W-1:0]   i_vertex_c,
    input  logic [rmch_pkg::VEC_W-1:0]   i_face_normal,
    input  logic                         i_shadow_test,
    input  logic                         i_last_face,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic                         o_hit_found,
    output logic [rmch_pkg::DIST_W-1:0]  o_hit_distance,
    output logic [rmch_pkg::QN_W-1:0]    o_hit_beta,
    output logic [rmch_pkg::QN_W-1:0]    o_hit_gamma,
    output logic [rmch_pkg::VEC_W-1:0]   o_hit_normal,
    output logic [rmch_pkg::FACE_W-1:0]  o_hit_face
);

    localparam int unsigned OW = rmch_pkg::OPR_W;
    localparam int unsigned CW = rmch_pkg::CMP_W;
    localparam int unsigned MW = rmch_pkg::MUL_W;
    localparam int unsigned LW = rmch_pkg::LO_W;
    localparam int unsigned XW = rmch_pkg::XPR_W;
    localparam int unsigned DW = rmch_pkg::DET_W;
    localparam int unsigned QW = rmch_pkg::Q_W;
    localparam int unsigned NW = rmch_pkg::QN_W;
    localparam int unsigned TW = rmch_pkg::DIST_W;
    localparam int unsigned FCW = rmch_pkg::FACE_W;
    localparam logic [24:0] MaxFaces = 25'(MAX_FACES);

    logic signed [OW-1:0] r_op [rmch_pkg::NUM_OPS];
    logic signed [XW-1:0] r_x [rmch_pkg::NUM_X];
    logic signed [DW-1:0] r_acc;
    logic signed [DW-1:0] r_deta, r_detb, r_detg, r_dett;
    logic                 r_dn_neg;
    logic                 r_shadow;
    logic                 r_last;
    logic [rmch_pkg::VEC_W-1:0] r_normal;
    logic                 r_hit;
    logic [TW-1:0]        r_t;
    logic [NW-1:0]        r_b, r_g;

    logic                 r_any;
    logic [TW-1:0]        r_bdist;
    logic [NW-1:0]        r_bbeta, r_bgamma;
    logic [rmch_pkg::VEC_W-1:0] r_bnormal;
    logic [FCW-1:0]       r_bface;
    logic [FCW-1:0]       r_cnt;
    logic                 r_out_valid;

    rmch_pkg::t_step      w_st;
    logic signed [OW-1:0] w_a;
    logic signed [MW-1:0] w_b;
    logic signed [XW-1:0] w_prod;
    logic signed [DW-1:0] w_term;
    logic signed [DW-1:0] w_base;
    logic signed [DW-1:0] w_acc;
    logic signed [DW-1:0] w_bg;
    logic                 w_cand;
    logic [DW-1:0]        w_num;
    logic                 w_div_done;
    logic                 w_div_sat;
    logic [QW-1:0]        w_quot;
    logic                 w_take;
    logic [FCW:0]         w_cnt_inc;
    logic [FCW-1:0]       w_cnt_next;

    function automatic logic signed [OW-1:0] sx(logic [rmch_pkg::VEC_W-1:0] v, int k);
        logic [CW-1:0] f;
        f = v[CW*k +: CW];
        return {f[CW-1], f};
    endfunction

    assign w_st = rmch_pkg::step_rom(i_cmd.step);
    assign w_a  = r_op[w_st.a_sel];

    always_comb begin
        unique case (w_st.b_kind)
            rmch_pkg::BK_OP:  w_b = {{(MW-OW){r_op[w_st.b_sel][OW-1]}}, r_op[w_st.b_sel]};
            rmch_pkg::BK_XLO: w_b = {1'b0, r_x[w_st.b_sel][LW-1:0]};
            rmch_pkg::BK_XHI: w_b = {r_x[w_st.b_sel][XW-1], r_x[w_st.b_sel][XW-1:LW]};
            default:          w_b = '0;
        endcase
    end

    assign w_prod = w_a * w_b;
    assign w_term = w_st.shift ? ({{(DW-XW){w_prod[XW-1]}}, w_prod} <<< LW)
                               : {{(DW-XW){w_prod[XW-1]}}, w_prod};
    assign w_base = w_st.first ? '0 : r_acc;
    assign w_acc  = w_st.sub ? (w_base - w_term) : (w_base + w_term);

    assign w_bg   = r_detb + r_detg;
    assign w_cand = (r_shadow || r_dn_neg) && (r_deta != '0) && !r_dett[DW-1]
                    && (r_dett != '0) && !r_detb[DW-1] && !r_detg[DW-1]
                    && (r_deta >= w_bg);

    always_comb begin
        unique case (i_cmd.div_sel)
            rmch_pkg::DIV_T: w_num = r_dett;
            rmch_pkg::DIV_B: w_num = r_detb;
            rmch_pkg::DIV_G: w_num = r_detg;
            default:         w_num = r_dett;
        endcase
    end

    rmch_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_wide  (i_cmd.div_sel == rmch_pkg::DIV_T),
        .i_num   (w_num),
        .i_den   (r_deta),
        .o_done  (w_div_done),
        .o_sat   (w_div_sat),
        .o_quot  (w_quot)
    );

    assign w_take     = r_hit && (!r_any || (r_t < r_bdist));
    assign w_cnt_inc  = {1'b0, r_cnt} + 1'b1;
    assign w_cnt_next = (25'(w_cnt_inc) >= MaxFaces) ? '0 : w_cnt_inc[FCW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < 3; k++) begin
                r_op[rmch_pkg::OP_AB + k] <= sx(i_vertex_a, k) - sx(i_vertex_b, k);
                r_op[rmch_pkg::OP_AC + k] <= sx(i_vertex_a, k) - sx(i_vertex_c, k);
                r_op[rmch_pkg::OP_AE + k] <= sx(i_vertex_a, k) - sx(i_ray_origin, k);
                r_op[rmch_pkg::OP_D + k]  <= sx(i_ray_direction, k);
                r_op[rmch_pkg::OP_N + k]  <= sx(i_face_normal, k);
            end
            r_normal <= i_face_normal;
            r_shadow <= i_shadow_test;
            r_last   <= i_last_face;
        end
        if (i_cmd.mac) begin
            r_acc <= w_acc;
            if (w_st.last) begin
                priority if (w_st.dest < 4'(rmch_pkg::NUM_X)) begin
                    r_x[w_st.dest] <= w_acc[XW-1:0];
                end else if (w_st.dest == rmch_pkg::DST_DETA) begin
                    r_deta <= w_acc;
                end else if (w_st.dest == rmch_pkg::DST_DETB) begin
                    r_detb <= w_acc;
                end else if (w_st.dest == rmch_pkg::DST_DETG) begin
                    r_detg <= w_acc;
                end else if (w_st.dest == rmch_pkg::DST_DETT) begin
                    r_dett <= w_acc;
                end else begin
                    r_dn_neg <= w_acc[DW-1];
                end
            end
        end
        if (i_cmd.norm && r_deta[DW-1]) begin
            r_deta <= -r_deta;
            r_detb <= -r_detb;
            r_detg <= -r_detg;
            r_dett <= -r_dett;
        end
        if (i_cmd.eval) begin
            r_hit <= w_cand;
        end
        if (w_div_done) begin
            unique case (i_cmd.div_sel)
                rmch_pkg::DIV_T: r_t <= (w_div_sat || (w_quot >= {1'b0, {TW{1'b1}}}))
                                        ? '1 : w_quot[TW-1:0];
                rmch_pkg::DIV_B: r_b <= w_quot[NW-1:0];
                rmch_pkg::DIV_G: r_g <= w_quot[NW-1:0];
                default:         r_t <= '1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any       <= 1'b0;
            r_bdist     <= '1;
            r_bbeta     <= '0;
            r_bgamma    <= '0;
            r_bnormal   <= '0;
            r_bface     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.update) begin
                if (r_last) begin
                    r_out_valid    <= 1'b1;
                    o_hit_found    <= w_take || r_any;
                    o_hit_distance <= w_take ? r_t : r_bdist;
                    o_hit_beta     <= w_take ? r_b : r_bbeta;
                    o_hit_gamma    <= w_take ? r_g : r_bgamma;
                    o_hit_normal   <= w_take ? r_normal : r_bnormal;
                    o_hit_face     <= w_take ? r_cnt : r_bface;
                    r_any          <= 1'b0;
                    r_bdist        <= '1;
                    r_bbeta        <= '0;
                    r_bgamma       <= '0;
                    r_bnormal      <= '0;
                    r_bface        <= '0;
                    r_cnt          <= '0;
                end else begin
                    if (w_take) begin
                        r_any     <= 1'b1;
                        r_bdist   <= r_t;
                        r_bbeta   <= r_b;
                        r_bgamma  <= r_g;
                        r_bnormal <= r_normal;
                        r_bface   <= r_cnt;
                    end
                    r_cnt <= w_cnt_next;
                end
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.div_done = w_div_done;
    assign o_stat.hit_cand = r_hit;
    assign o_stat.last     = r_last;
    assign o_stat.out_full = r_out_valid;

endmodule

// File: src/rmch_ctrl.sv
// ----------------------------------------------------------------------------
// rmch_ctrl
// Controller that sequences one triangle through the multiply-accumulate
// steps, the checks, the three divisions of a hit candidate and the nearest-hit update.
// ----------------------------------------------------------------------------
module rmch_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rmch_pkg::t_stat  i_stat,
    output rmch_pkg::t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAC,
        S_NORM,
        S_EVAL,
        S_CHK,
        S_DIV_T,
        S_DIV_B,
        S_DIV_G,
        S_UPD,
        S_DONE
    } t_state;

    t_state                      r_state;
    logic                        r_ready;
    logic                        r_mac;
    logic [rmch_pkg::STEP_W-1:0] r_step;
    logic                        r_norm;
    logic                        r_eval;
    logic                        r_div_start;
    rmch_pkg::t_divsel           r_div_sel;
    logic                        r_update;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ready     <= 1'b1;
            r_mac       <= 1'b0;
            r_step      <= '0;
            r_norm      <= 1'b0;
            r_eval      <= 1'b0;
            r_div_start <= 1'b0;
            r_div_sel   <= rmch_pkg::DIV_T;
            r_update    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && r_ready) begin
                        r_ready <= 1'b0;
                        r_mac   <= 1'b1;
                        r_step  <= '0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (r_step == rmch_pkg::STEP_W'(rmch_pkg::NUM_STEPS - 1)) begin
                        r_mac   <= 1'b0;
                        r_norm  <= 1'b1;
                        r_state <= S_NORM;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_NORM: begin
                    r_norm  <= 1'b0;
                    r_eval  <= 1'b1;
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_eval  <= 1'b0;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (i_stat.hit_cand) begin
                        r_div_sel   <= rmch_pkg::DIV_T;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV_T;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_DIV_T: begin
                    r_div_start <= 1'b0;
                    if (i_stat.div_done) begin
                        r_div_sel   <= rmch_pkg::DIV_B;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV_B;
                    end
                end
                S_DIV_B: begin
                    r_div_start <= 1'b0;
                    if (i_stat.div_done) begin
                        r_div_sel   <= rmch_pkg::DIV_G;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV_G;
                    end
                end
                S_DIV_G: begin
                    r_div_start <= 1'b0;
                    if (i_stat.div_done) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (!(i_stat.last && i_stat.out_full)) begin
                        r_update <= 1'b1;
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_update <= 1'b0;
                    r_ready  <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready = r_ready;

    always_comb begin
        o_cmd.load      = i_valid && r_ready;
        o_cmd.mac       = r_mac;
        o_cmd.step      = r_step;
        o_cmd.norm      = r_norm;
        o_cmd.eval      = r_eval;
        o_cmd.div_start = r_div_start;
        o_cmd.div_sel   = r_div_sel;
        o_cmd.update    = r_update;
    end

endmodule

// File: src/ray_mesh_closest_hit.sv
// ----------------------------------------------------------------------------
// ray_mesh_closest_hit
// Nearest ray/triangle hit over a stream of triangles, tested by Cramer's rule.
// ----------------------------------------------------------------------------
// Each input transfer carries one triangle, its face normal and the ray. The
// triangle flagged last_face closes the mesh: one result transfer follows with
// the nearest hit, and the kept state returns to its reset values.
// A single 22x24 multiplier runs 45 multiply-accumulate steps for the normal
// dot product, three cross products and four determinants; a one-bit-a-cycle
// divider then forms t (33 steps), beta and gamma (17 steps each) for a hit candidate.
// Input ready is high only while no triangle is in work.
// The result sits in an output register; the next mesh's triangles are taken
// while it waits. A final triangle whose result would overwrite an untaken
// result waits until the receiver takes it.
// Reset is synchronous and active low; reset itself sets ready high.
// ----------------------------------------------------------------------------
module ray_mesh_closest_hit #(
    parameter int unsigned MAX_FACES = 65536
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [62:0]   i_ray_origin,
    input  logic [62:0]   i_ray_direction,
    input  logic [62:0]   i_vertex_a,
    input  logic [62:0]   i_vertex_b,
    input  logic [62:0]   i_vertex_c,
    input  logic [62:0]   i_face_normal,
    input  logic          i_shadow_test,
    input  logic          i_last_face,
    output logic          o_valid,
    input  logic          i_ready,
    output logic          o_hit_found,
    output logic [31:0]   o_hit_distance,
    output logic [16:0]   o_hit_beta,
    output logic [16:0]   o_hit_gamma,
    output logic [62:0]   o_hit_normal,
    output logic [15:0]   o_hit_face
);

    rmch_pkg::t_cmd  w_cmd;
    rmch_pkg::t_stat w_stat;

    rmch_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    rmch_dp #(
        .MAX_FACES (MAX_FACES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_ray_origin    (i_ray_origin),
        .i_ray_direction (i_ray_direction),
        .i_vertex_a      (i_vertex_a),
        .i_vertex_b      (i_vertex_b),
        .i_vertex_c      (i_vertex_c),
        .i_face_normal   (i_face_normal),
        .i_shadow_test   (i_shadow_test),
        .i_last_face     (i_last_face),
        .i_out_ready     (i_ready),
        .o_out_valid     (o_valid),
        .o_hit_found     (o_hit_found),
        .o_hit_distance  (o_hit_distance),
        .o_hit_beta      (o_hit_beta),
        .o_hit_gamma     (o_hit_gamma),
        .o_hit_normal    (o_hit_normal),
        .o_hit_face      (o_hit_face)
    );

`ifndef SYNTHESIS
    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit_found) |-> (o_hit_distance == 32'hFFFF_FFFF)
            && (o_hit_face == 16'd0) && (o_hit_beta == 17'd0))
        else $error("Miss result carries hit fields.");

    a_bary_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit_found) |-> (({1'b0, o_hit_beta} + {1'b0, o_hit_gamma}) <= 18'd65536))
        else $error("Barycentric sum exceeds one.");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("Input taken while a triangle is in work.");
`endif

endmodule

// File: bench/ray_mesh_closest_hit_tb.sv
// ----------------------------------------------------------------------------
// ray_mesh_closest_hit_tb
// Self-checking bench for the nearest ray/triangle hit unit.
// ----------------------------------------------------------------------------
// Triangles are sent over the input channel with random gaps, and results are
// taken with random back-pressure. A predictor in the bench tracks the nearest
// hit of each mesh with exact wide determinants, and every result transfer is
// compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module ray_mesh_closest_hit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUM_FACES_MAX = 65536;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef logic [rmch_pkg::VEC_W-1:0] t_vec;
    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic                          found;
        logic [rmch_pkg::DIST_W-1:0]   distance;
        logic [rmch_pkg::QN_W-1:0]     beta;
        logic [rmch_pkg::QN_W-1:0]     gamma;
        t_vec                          normal;
        logic [rmch_pkg::FACE_W-1:0]   face;
    } t_hit;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_vec i_ray_origin;
    t_vec i_ray_direction;
    t_vec i_vertex_a;
    t_vec i_vertex_b;
    t_vec i_vertex_c;
    t_vec i_face_normal;
    logic i_shadow_test;
    logic i_last_face;
    logic o_valid;
    logic i_ready;
    logic o_hit_found;
    logic [rmch_pkg::DIST_W-1:0] o_hit_distance;
    logic [rmch_pkg::QN_W-1:0] o_hit_beta;
    logic [rmch_pkg::QN_W-1:0] o_hit_gamma;
    t_vec o_hit_normal;
    logic [rmch_pkg::FACE_W-1:0] o_hit_face;

    ray_mesh_closest_hit #(.MAX_FACES(NUM_FACES_MAX)) u_dut (.*);

    t_hit   pending_hits[$];
    t_hit   nearest;
    int     face_pos;
    int     errors;
    longint cycle_count;
    int     hold_cycles;
    bit     steady_send;
    bit     steady_take;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_vec pack3(int x, int y, int z);
        logic [20:0] px, py, pz;
        px = x[20:0];
        py = y[20:0];
        pz = z[20:0];
        return {pz, py, px};
    endfunction

    function automatic longint comp(t_vec v, int k);
        logic signed [20:0] c;
        c = v[21*k +: 21];
        return longint'(c);
    endfunction

    function automatic int srand(int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    function automatic t_vec rand_vec();
        return t_vec'({$urandom, $urandom});
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // u . (v x w) on exact signed integers.
    function automatic t_wide triple(longint u[3], longint v[3], longint w[3]);
        t_wide cx, cy, cz, u0, u1, u2;
        cx = v[1] * w[2] - v[2] * w[1];
        cy = v[2] * w[0] - v[0] * w[2];
        cz = v[0] * w[1] - v[1] * w[0];
        u0 = u[0];
        u1 = u[1];
        u2 = u[2];
        return u0 * cx + u1 * cy + u2 * cz;
    endfunction

    // floor(num * 2^16 / den), limited to 34 bits.
    function automatic logic [63:0] frac_quot(t_wide num, t_wide den);
        logic [127:0] n, d, q;
        n = num;
        d = den;
        n = n << 16;
        if (n >= (d << 34)) return 64'h3_FFFF_FFFF;
        q = n / d;
        return q[63:0];
    endfunction

    function automatic void clear_nearest();
        nearest.found    = 1'b0;
        nearest.distance = '1;
        nearest.beta     = '0;
        nearest.gamma    = '0;
        nearest.normal   = '0;
        nearest.face     = '0;
        face_pos         = 0;
    endfunction

    function automatic void track_face(t_vec e, t_vec d, t_vec a, t_vec b, t_vec c,
                                       t_vec nrm, logic shadow, logic last);
        longint dv[3], ab[3], ac[3], ae[3];
        longint dn;
        t_wide  det_a, det_b, det_g, det_t;
        logic [63:0] q;
        logic [rmch_pkg::DIST_W-1:0] dist_q;
        dn = 0;
        dist_q = '1;
        for (int k = 0; k < 3; k++) begin
            dv[k] = comp(d, k);
            ab[k] = comp(a, k) - comp(b, k);
            ac[k] = comp(a, k) - comp(c, k);
            ae[k] = comp(a, k) - comp(e, k);
            dn += dv[k] * comp(nrm, k);
        end
        if (shadow || dn < 0) begin
            det_a = triple(ab, ac, dv);
            det_b = triple(ae, ac, dv);
            det_g = triple(ab, ae, dv);
            det_t = triple(ab, ac, ae);
            if (det_a != 0) begin
                if (det_a < 0) begin
                    det_a = -det_a;
                    det_b = -det_b;
                    det_g = -det_g;
                    det_t = -det_t;
                end
                if (det_t > 0 && det_b >= 0 && det_g >= 0 && det_a >= det_b + det_g) begin
                    q = frac_quot(det_t, det_a);
                    dist_q = (q >= 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
                    if (!nearest.found || dist_q < nearest.distance) begin
                        nearest.found    = 1'b1;
                        nearest.distance = dist_q;
                        q = frac_quot(det_b, det_a);
                        nearest.beta     = q[rmch_pkg::QN_W-1:0];
                        q = frac_quot(det_g, det_a);
                        nearest.gamma    = q[rmch_pkg::QN_W-1:0];
                        nearest.normal   = nrm;
                        nearest.face     = face_pos[rmch_pkg::FACE_W-1:0];
                    end
                end
            end
        end
        face_pos = (face_pos + 1 >= NUM_FACES_MAX) ? 0 : face_pos + 1;
        if (last) begin
            pending_hits.push_back(nearest);
            clear_nearest();
        end
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s: got %0h, expected %0h", field, got, want);
        errors++;
    endtask

    // Result side: random back-pressure, long holds on request.
    initial begin
        t_hit want;
        i_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (o_valid && i_ready) begin
                if (pending_hits.size() == 0) begin
                    $display("unexpected result transfer");
                    errors++;
                end else begin
                    want = pending_hits.pop_front();
                    if (o_hit_found !== want.found)
                        report_mismatch("hit_found", 64'(o_hit_found), 64'(want.found));
                    if (o_hit_distance !== want.distance)
                        report_mismatch("hit_distance", 64'(o_hit_distance),
                                        64'(want.distance));
                    if (o_hit_beta !== want.beta)
                        report_mismatch("hit_beta", 64'(o_hit_beta), 64'(want.beta));
                    if (o_hit_gamma !== want.gamma)
                        report_mismatch("hit_gamma", 64'(o_hit_gamma), 64'(want.gamma));
                    if (o_hit_normal !== want.normal)
                        report_mismatch("hit_normal", 64'(o_hit_normal), 64'(want.normal));
                    if (o_hit_face !== want.face)
                        report_mismatch("hit_face", 64'(o_hit_face), 64'(want.face));
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_ready <= 1'b0;
            end else if (steady_take) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) < 65);
            end
            @(posedge i_clk);
        end
    end

    task automatic send_face(t_vec e, t_vec d, t_vec a, t_vec b, t_vec c, t_vec nrm,
                             logic shadow, logic last);
        i_valid         <= 1'b1;
        i_ray_origin    <= e;
        i_ray_direction <= d;
        i_vertex_a      <= a;
        i_vertex_b      <= b;
        i_vertex_c      <= c;
        i_face_normal   <= nrm;
        i_shadow_test   <= shadow;
        i_last_face     <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        track_face(e, d, a, b, c, nrm, shadow, last);
    endtask

    task automatic pause_sender();
        int n;
        n = steady_send ? 0 : gap_len();
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
    endtask

    // A triangular target in the plane x = px, centered on the x axis.
    task automatic send_plane(int px, t_vec e, t_vec d, int nx, logic shadow, logic last);
        send_face(e, d, pack3(px, -4096, -4096), pack3(px, 8192, -4096),
                  pack3(px, -4096, 8192), pack3(nx, 0, 0), shadow, last);
        pause_sender();
    endtask

    task automatic test_field_extremes();
        t_vec ones;
        t_vec mins;
        ones = '1;
        mins = pack3(-1048576, -1048576, -1048576);
        send_face(ones, ones, ones, ones, ones, ones, 1'b1, 1'b1);
        pause_sender();
        send_face('0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
        pause_sender();
        send_face(mins, pack3(1048575, 1048575, 1048575), pack3(1048575, -1048576, 0),
                  pack3(-1048576, 1048575, 0), pack3(0, 0, 1048575), mins, 1'b1, 1'b0);
        send_face(pack3(1048575, 0, -1048576), mins, mins, pack3(1048575, 1048575, 0),
                  pack3(0, 1048575, 1048575), pack3(1048575, 0, 0), 1'b1, 1'b1);
        pause_sender();
    endtask

    task automatic test_culling_and_zero_det();
        t_vec d;
        d = pack3(1024, 0, 0);
        send_plane(10240, '0, d, 1, 1'b0, 1'b1);
        send_plane(10240, '0, d, 1, 1'b1, 1'b1);
        send_plane(10240, '0, d, 0, 1'b0, 1'b1);
        send_plane(10240, '0, d, -1, 1'b0, 1'b1);
        send_face('0, d, pack3(2048, 0, 0), pack3(2048, 0, 0), pack3(2048, 5, 7),
                  pack3(-1, 0, 0), 1'b1, 1'b1);
        pause_sender();
        send_plane(-10240, '0, d, -1, 1'b1, 1'b1);
    endtask

    task automatic test_distance_and_ties();
        send_plane(1024000, '0, pack3(1, 0, 0), -1, 1'b0, 1'b1);
        send_plane(1024000, '0, pack3(1, 0, 0), -1, 1'b0, 1'b0);
        send_plane(2048, '0, pack3(1, 0, 0), -1, 1'b0, 1'b1);
        send_plane(8192, '0, pack3(1024, 0, 0), -1, 1'b0, 1'b0);
        send_plane(8192, '0, pack3(1024, 0, 0), -1, 1'b0, 1'b0);
        send_plane(4096, '0, pack3(1024, 0, 0), -1, 1'b0, 1'b0);
        send_plane(4096, '0, pack3(1024, 0, 0), -1, 1'b0, 1'b1);
        send_face('0, pack3(1024, 0, 0), pack3(2048, 0, 0), pack3(2048, 4096, 0),
                  pack3(2048, 0, 4096), pack3(-1, 0, 0), 1'b0, 1'b1);
        pause_sender();
    endtask

    // A mesh for one ray: mostly triangles built around points on the ray.
    task automatic send_mesh(int faces);
        t_vec e, d, a, b, c, nrm;
        int ex, ey, ez, dx, dy, dz, s, qx, qy, qz, ux, uy, uz, vx, vy, vz;
        ex = srand(131072);
        ey = srand(131072);
        ez = srand(131072);
        dx = srand(65536);
        dy = srand(65536);
        dz = srand(65536);
        e = pack3(ex, ey, ez);
        d = pack3(dx, dy, dz);
        for (int f = 0; f < faces; f++) begin
            if ($urandom_range(0, 99) < 80) begin
                s  = $urandom_range(1, 16);
                qx = ex + dx * s / 8;
                qy = ey + dy * s / 8;
                qz = ez + dz * s / 8;
                ux = srand(16384);
                uy = srand(16384);
                uz = srand(16384);
                vx = srand(16384);
                vy = srand(16384);
                vz = srand(16384);
                a = pack3(qx + ux, qy + uy, qz + uz);
                b = pack3(qx + vx, qy + vy, qz + vz);
                c = pack3(qx - ux - vx, qy - uy - vy, qz - uz - vz);
                if ($urandom_range(0, 3) != 0) nrm = pack3(-dx, -dy, -dz);
                else nrm = pack3(srand(1048575), srand(1048575), srand(1048575));
                send_face(e, d, a, b, c, nrm, ($urandom_range(0, 3) == 0),
                          f == faces - 1);
            end else begin
                send_face(rand_vec(), rand_vec(), rand_vec(), rand_vec(), rand_vec(),
                          rand_vec(), 1'($urandom_range(0, 1)), f == faces - 1);
            end
            pause_sender();
        end
    endtask

    task automatic test_random_meshes(int items);
        int sent, n;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(0, 19) == 0) steady_send = ~steady_send;
            if ($urandom_range(0, 19) == 0) steady_take = ~steady_take;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
            send_mesh(n);
            sent += n;
        end
        steady_send = 1'b0;
        steady_take = 1'b0;
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_cycles = 1500;
        steady_send = 1'b1;
        for (int m = 0; m < 4; m++) send_mesh(2);
        steady_send = 1'b0;
        wait_drained();
    endtask

    initial begin
        errors = 0;
        cycle_count = 0;
        hold_cycles = 0;
        steady_send = 1'b0;
        steady_take = 1'b0;
        clear_nearest();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ray_origin = '0;
        i_ray_direction = '0;
        i_vertex_a = '0;
        i_vertex_b = '0;
        i_vertex_c = '0;
        i_face_normal = '0;
        i_shadow_test = 1'b0;
        i_last_face = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_culling_and_zero_det();
        test_distance_and_ties();
        test_random_meshes(250);
        test_backpressure();
        test_random_meshes(260);

        wait_drained();
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: files.f
src/rmch_pkg.sv
src/rmch_div.sv
src/rmch_dp.sv
src/rmch_ctrl.sv
src/ray_mesh_closest_hit.sv
bench/ray_mesh_closest_hit_tb.sv
